/* rtl/core/scw_pkg.sv */
package scw_pkg;

  // Default coordinate width of box and crop fields
  localparam int unsigned CoordBitsDefault = 12;

  // Fixed register widths
  localparam int unsigned PadBits   = 10;
  localparam int unsigned FracBits  = 9;
  localparam int unsigned CfgIdxBits = 3;

  // Q8 fractional shift and the saturation point of the max fraction
  localparam int unsigned QShift  = 8;
  localparam int unsigned FracOne = 256;

  // Register reset values
  localparam int unsigned PadScaleRst  = 384;
  localparam int unsigned MinSideRst   = 64;
  localparam int unsigned MaxFracRst   = 192;
  localparam int unsigned FrameWidthRst  = 320;
  localparam int unsigned FrameHeightRst = 240;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    RegPadScale    = 3'd0,
    RegMinSide     = 3'd1,
    RegMaxFrac     = 3'd2,
    RegFrameWidth  = 3'd3,
    RegFrameHeight = 3'd4
  } cfg_reg_e;

endpackage

/* rtl/core/scw_box_if.sv */
interface scw_box_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         box_valid;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_top;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;

  modport source (
    output valid, box_valid, box_left, box_top, box_width, box_height,
    input  ready
  );

  modport sink (
    input  valid, box_valid, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

/* rtl/core/scw_crop_if.sv */
interface scw_crop_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  crop_valid;
  logic [COORD_BITS-1:0] crop_left;
  logic [COORD_BITS-1:0] crop_top;
  logic [COORD_BITS-1:0] crop_side;

  modport source (
    output valid, crop_valid, crop_left, crop_top, crop_side,
    input  ready
  );

  modport sink (
    input  valid, crop_valid, crop_left, crop_top, crop_side,
    output ready
  );
endinterface

/* rtl/core/scw_place.sv */
// Clamp one window origin inside the frame and round it down to even.
// The side is known to be no larger than the frame extent.
module scw_place #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic signed [COORD_BITS:0]   start_i,
  input  logic        [COORD_BITS-1:0] side_i,
  input  logic        [COORD_BITS-1:0] limit_i,
  output logic        [COORD_BITS-1:0] pos_o
);
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic [COORD_BITS-1:0] pos;

  // negative start clamps to zero, far edge clamps to limit - side
  always_comb begin
    lo    = start_i[COORD_BITS] ? '0 : start_i[COORD_BITS-1:0];
    hi    = limit_i - side_i;
    pos   = (lo > hi) ? hi : lo;
    pos_o = {pos[COORD_BITS-1:1], 1'b0};
  end
endmodule

/* rtl/core/square_crop_window_calc.sv */
// Square crop window calculator: for each box transaction on box_i it returns
// one crop transaction on crop_o, in order. The side is the longest box side
// times pad_scale_q8 (Q8, truncated), raised to min_side; if it reaches the
// shortest frame side times max_frac_q8 (Q8, saturated at 1.0) no crop is
// given (crop_valid 0, other fields 0). Otherwise the even side is centered on
// the box center, clamped inside the frame, and the origin rounded to even.
// One box is taken every cycle unless backpressure from crop_o stalls the
// pipeline, which has four stages: stage 2 holds the two multipliers, the
// others adds and compares. Each stage stalls only when the one after it is
// full and stalled, so no item is lost or repeated under backpressure.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and must only change while no transaction is in flight; writes to an index
// beyond frame_height are ignored.
module square_crop_window_calc #(
  parameter int unsigned COORD_BITS = scw_pkg::CoordBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,

  scw_box_if.sink    box_i,
  scw_crop_if.source crop_o,

  input  logic                            cfg_we_i,
  input  logic [scw_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [((COORD_BITS > scw_pkg::PadBits) ? COORD_BITS : scw_pkg::PadBits)-1:0]
                                          cfg_data_i
);
  import scw_pkg::*;

  localparam int unsigned C = COORD_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PadBits-1:0]  pad_scale_q;
  logic [C-1:0]        min_side_q;
  logic [FracBits-1:0] max_frac_q;
  logic [C-1:0]        frame_width_q;
  logic [C-1:0]        frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_scale_q    <= PadBits'(PadScaleRst);
      min_side_q     <= C'(MinSideRst);
      max_frac_q     <= FracBits'(MaxFracRst);
      frame_width_q  <= C'(FrameWidthRst);
      frame_height_q <= C'(FrameHeightRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPadScale:    pad_scale_q    <= cfg_data_i[PadBits-1:0];
        RegMinSide:     min_side_q     <= cfg_data_i[C-1:0];
        RegMaxFrac:     max_frac_q     <= cfg_data_i[FracBits-1:0];
        RegFrameWidth:  frame_width_q  <= cfg_data_i[C-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i[C-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || crop_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign box_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= box_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: qualify the box, pick sides, compute the box center
  // ---------------------------------------------------------------------------
  logic                ok1_d, ok1_q;
  logic [C-1:0]        longest1_d, longest1_q;
  logic [C-1:0]        shortest1_d, shortest1_q;
  logic [FracBits-1:0] frac1_d, frac1_q;
  logic signed [C:0]   cx1_d, cx1_q;
  logic signed [C:0]   cy1_d, cy1_q;

  always_comb begin
    ok1_d = box_i.box_valid && (box_i.box_width != '0) && (box_i.box_height != '0)
            && (frame_width_q != '0) && (frame_height_q != '0);
    longest1_d  = (box_i.box_width > box_i.box_height) ? box_i.box_width
                                                       : box_i.box_height;
    shortest1_d = (frame_width_q < frame_height_q) ? frame_width_q : frame_height_q;
    frac1_d     = (max_frac_q > FracBits'(FracOne)) ? FracBits'(FracOne) : max_frac_q;
    cx1_d = $signed({box_i.box_left[C-1], box_i.box_left})
          + $signed({2'b00, box_i.box_width[C-1:1]});
    cy1_d = $signed({box_i.box_top[C-1], box_i.box_top})
          + $signed({2'b00, box_i.box_height[C-1:1]});
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ok1_q       <= ok1_d;
      longest1_q  <= longest1_d;
      shortest1_q <= shortest1_d;
      frac1_q     <= frac1_d;
      cx1_q       <= cx1_d;
      cy1_q       <= cy1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scaled side and size limit, both Q8 products
  // ---------------------------------------------------------------------------
  logic [C+PadBits-1:0]  side_prod;
  logic [C+FracBits-1:0] limit_prod;
  logic                  ok2_q;
  logic [C+1:0]          side2_q;
  logic [C:0]            limit2_q;
  logic signed [C:0]     cx2_q, cy2_q;

  always_comb begin
    side_prod  = {{PadBits{1'b0}}, longest1_q} * {{C{1'b0}}, pad_scale_q};
    limit_prod = {{FracBits{1'b0}}, shortest1_q} * {{C{1'b0}}, frac1_q};
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ok2_q    <= ok1_q;
      side2_q  <= side_prod[C+PadBits-1:QShift];
      limit2_q <= limit_prod[C+FracBits-1:QShift];
      cx2_q    <= cx1_q;
      cy2_q    <= cy1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: apply minimum side, check limit, center the even side
  // ---------------------------------------------------------------------------
  logic [C+1:0]      side_m;
  logic [C-2:0]      half;
  logic              ok3_d, ok3_q;
  logic [C-1:0]      side3_q;
  logic signed [C:0] sx3_q, sy3_q;

  always_comb begin
    side_m = (side2_q < {2'b00, min_side_q}) ? {2'b00, min_side_q} : side2_q;
    ok3_d  = ok2_q && (side_m < {1'b0, limit2_q});
    half   = side_m[C-1:1];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ok3_q   <= ok3_d;
      side3_q <= {side_m[C-1:1], 1'b0};
      sx3_q   <= cx2_q - $signed({2'b00, half});
      sy3_q   <= cy2_q - $signed({2'b00, half});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clamp inside the frame, output register
  // ---------------------------------------------------------------------------
  logic [C-1:0] pos_x, pos_y;
  logic         crop_valid_q;
  logic [C-1:0] crop_left_q, crop_top_q, crop_side_q;

  scw_place #(.COORD_BITS(C)) u_place_x (
    .start_i (sx3_q),
    .side_i  (side3_q),
    .limit_i (frame_width_q),
    .pos_o   (pos_x)
  );

  scw_place #(.COORD_BITS(C)) u_place_y (
    .start_i (sy3_q),
    .side_i  (side3_q),
    .limit_i (frame_height_q),
    .pos_o   (pos_y)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      crop_valid_q <= ok3_q;
      crop_left_q  <= ok3_q ? pos_x : '0;
      crop_top_q   <= ok3_q ? pos_y : '0;
      crop_side_q  <= ok3_q ? side3_q : '0;
    end
  end

  assign crop_o.valid      = v4_q;
  assign crop_o.crop_valid = crop_valid_q;
  assign crop_o.crop_left  = crop_left_q;
  assign crop_o.crop_top   = crop_top_q;
  assign crop_o.crop_side  = crop_side_q;

endmodule

/* tb/square_crop_window_calc_tb.sv */
`timescale 1ns / 100ps

typedef logic        [scw_pkg::CoordBitsDefault-1:0] coord_t;
typedef logic signed [scw_pkg::CoordBitsDefault-1:0] scoord_t;
typedef logic        [scw_pkg::PadBits-1:0]          pad_t;
typedef logic        [scw_pkg::FracBits-1:0]         frac_t;
typedef logic        [scw_pkg::CfgIdxBits-1:0]       cfg_idx_t;

typedef struct packed {
  logic    valid;
  scoord_t left;
  scoord_t top;
  coord_t  width;
  coord_t  height;
} box_t;

typedef struct packed {
  logic   valid;
  coord_t left;
  coord_t top;
  coord_t side;
} crop_t;

typedef struct packed {
  pad_t   pad;
  coord_t min_side;
  frac_t  frac;
  coord_t fw;
  coord_t fh;
} cfg_t;

// Crop window predictor plus in-order store of expected crop transactions
class crop_window_book;
  pad_t   pad_scale;
  coord_t min_side;
  frac_t  max_frac;
  coord_t frame_w;
  coord_t frame_h;
  crop_t  pending_crops[$];
  int     errors;
  int     boxes_noted;
  int     crops_checked;
  int     crops_valid;

  function new();
    pad_scale = pad_t'(scw_pkg::PadScaleRst);
    min_side  = coord_t'(scw_pkg::MinSideRst);
    max_frac  = frac_t'(scw_pkg::MaxFracRst);
    frame_w   = coord_t'(scw_pkg::FrameWidthRst);
    frame_h   = coord_t'(scw_pkg::FrameHeightRst);
    errors = 0;
    boxes_noted = 0;
    crops_checked = 0;
    crops_valid = 0;
  endfunction

  // Mirror of a register write; unknown indexes are dropped
  function void write_reg(cfg_idx_t idx, coord_t data);
    case (idx)
      scw_pkg::RegPadScale:    pad_scale = data[scw_pkg::PadBits-1:0];
      scw_pkg::RegMinSide:     min_side  = data;
      scw_pkg::RegMaxFrac:     max_frac  = data[scw_pkg::FracBits-1:0];
      scw_pkg::RegFrameWidth:  frame_w   = data;
      scw_pkg::RegFrameHeight: frame_h   = data;
      default: ;
    endcase
  endfunction

  function int shortest_side();
    return (frame_w < frame_h) ? int'(frame_w) : int'(frame_h);
  endfunction

  // Largest side (exclusive) for which a crop is still given
  function int side_limit();
    int frac_sat;
    frac_sat = (int'(max_frac) > scw_pkg::FracOne) ? scw_pkg::FracOne : int'(max_frac);
    return (shortest_side() * frac_sat) >> scw_pkg::QShift;
  endfunction

  // Push window inside [0, span), then round origin down to even
  function int clamp_origin(int start, int side, int span);
    if (start < 0) start = 0;
    if (start + side > span) start = span - side;
    if (start < 0) start = 0;
    return start & ~1;
  endfunction

  function crop_t predict_window(box_t b);
    crop_t r;
    int    longest, side, half, cx, cy;
    r = '0;
    if (!b.valid || b.width == 0 || b.height == 0 || frame_w == 0 || frame_h == 0)
      return r;
    longest = (b.width > b.height) ? int'(b.width) : int'(b.height);
    side = (longest * int'(pad_scale)) >> scw_pkg::QShift;
    if (side < int'(min_side)) side = int'(min_side);
    if (side >= side_limit()) return r;
    side = side & ~1;
    half = side >> 1;
    cx = int'(b.left) + int'(b.width) / 2;
    cy = int'(b.top) + int'(b.height) / 2;
    r.valid = 1'b1;
    r.left  = coord_t'(clamp_origin(cx - half, side, int'(frame_w)));
    r.top   = coord_t'(clamp_origin(cy - half, side, int'(frame_h)));
    r.side  = coord_t'(side);
    return r;
  endfunction

  function void note_box(box_t b);
    pending_crops.push_back(predict_window(b));
    boxes_noted++;
  endfunction

  function int pending();
    return pending_crops.size();
  endfunction

  function void report_field(string name, coord_t want, coord_t got);
    if (got !== want) begin
      errors++;
      $display("%0t crop mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_crop(crop_t got);
    crop_t want;
    crops_checked++;
    if (pending_crops.size() == 0) begin
      errors++;
      $display("%0t unexpected crop transaction: expected none, actual v=%0b l=%0d t=%0d s=%0d",
               $time, got.valid, got.left, got.top, got.side);
      return;
    end
    want = pending_crops.pop_front();
    if (want.valid) crops_valid++;
    report_field("crop_valid", coord_t'(want.valid), coord_t'(got.valid));
    report_field("crop_left", want.left, got.left);
    report_field("crop_top", want.top, got.top);
    report_field("crop_side", want.side, got.side);
  endfunction
endclass

module square_crop_window_calc_tb;

  localparam int unsigned CoordBits   = scw_pkg::CoordBitsDefault;
  localparam int unsigned CfgDataBits =
    (CoordBits > scw_pkg::PadBits) ? CoordBits : scw_pkg::PadBits;
  localparam int unsigned IdxCount    = 1 << scw_pkg::CfgIdxBits;
  localparam int          DrainCycles = 8;
  localparam int          IdleLimit   = 4000;
  localparam int          HoldCycles  = 400;

  typedef enum int {RxSteady, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  cfg_idx_t                        cfg_idx_i;
  logic [CfgDataBits-1:0]          cfg_data_i;

  scw_box_if  #(.COORD_BITS(CoordBits)) box_if ();
  scw_crop_if #(.COORD_BITS(CoordBits)) crop_if ();

  square_crop_window_calc #(.COORD_BITS(CoordBits)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .box_i      (box_if.sink),
    .crop_o     (crop_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  crop_window_book book;
  box_t            directed_boxes[$];
  int              burst_left = 0;
  int              hold_requests = 0;
  int              settings_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive one box and wait for its transaction; with gaps_on the sender may idle between bursts
  task automatic send_box(box_t b, bit gaps_on);
    int gap;
    box_if.valid      <= 1'b1;
    box_if.box_valid  <= b.valid;
    box_if.box_left   <= b.left;
    box_if.box_top    <= b.top;
    box_if.box_width  <= b.width;
    box_if.box_height <= b.height;
    do @(posedge clk_i); while (!(box_if.valid && box_if.ready));
    book.note_box(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        box_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic box_t mk_box(bit v, int l, int t, int w, int h);
    box_t b;
    b.valid  = v;
    b.left   = scoord_t'(l);
    b.top    = scoord_t'(t);
    b.width  = coord_t'(w);
    b.height = coord_t'(h);
    return b;
  endfunction

  // Mostly boxes near the crop limit and around the frame, some raw noise
  function automatic box_t make_box();
    box_t b;
    int   roll, lim, max_long, longest, other, x, y;
    roll = $urandom_range(0, 99);
    b = '0;
    b.valid = (roll >= 6);
    if (roll < 22) begin
      b.left   = scoord_t'($urandom);
      b.top    = scoord_t'($urandom);
      b.width  = coord_t'($urandom);
      b.height = coord_t'($urandom);
    end else begin
      lim = book.side_limit();
      max_long = (book.pad_scale == 0) ? 4095 : ((lim + 2) * 256) / int'(book.pad_scale);
      if (max_long < 1) max_long = 1;
      if (max_long > 4095) max_long = 4095;
      longest = $urandom_range(1, max_long);
      other   = $urandom_range(1, longest);
      if ($urandom_range(0, 1) == 1) begin
        b.width  = coord_t'(longest);
        b.height = coord_t'(other);
      end else begin
        b.width  = coord_t'(other);
        b.height = coord_t'(longest);
      end
      if (roll < 28) begin
        if (roll[0]) b.width = '0;
        else b.height = '0;
      end
      x = int'($urandom_range(0, int'(book.frame_w) + 8)) - int'($urandom_range(0, longest));
      y = int'($urandom_range(0, int'(book.frame_h) + 8)) - int'($urandom_range(0, longest));
      b.left = scoord_t'(x);
      b.top  = scoord_t'(y);
    end
    return b;
  endfunction

  task automatic send_random(int count, bit gaps_on);
    repeat (count) send_box(make_box(), gaps_on);
  endtask

  // Stop offering and let every outstanding crop drain
  task automatic settle();
    box_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, coord_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    book.write_reg(idx, data);
  endtask

  // Load all registers; optionally poke the unused indexes as well
  task automatic apply_setting(cfg_t c, bit poke_unused);
    write_reg(scw_pkg::RegPadScale, coord_t'(c.pad));
    write_reg(scw_pkg::RegMinSide, c.min_side);
    if (poke_unused) begin
      repeat (2)
        write_reg(cfg_idx_t'($urandom_range(int'(scw_pkg::RegFrameHeight) + 1, IdxCount - 1)),
                  coord_t'($urandom));
    end
    write_reg(scw_pkg::RegMaxFrac, coord_t'(c.frac));
    write_reg(scw_pkg::RegFrameWidth, c.fw);
    write_reg(scw_pkg::RegFrameHeight, c.fh);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t mk_cfg(int pad, int min_side, int frac, int fw, int fh);
    cfg_t c;
    c.pad      = pad_t'(pad);
    c.min_side = coord_t'(min_side);
    c.frac     = frac_t'(frac);
    c.fw       = coord_t'(fw);
    c.fh       = coord_t'(fh);
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.pad      = ($urandom_range(0, 4) == 0) ? pad_t'($urandom) : pad_t'($urandom_range(256, 640));
    c.min_side = ($urandom_range(0, 3) == 0) ? coord_t'($urandom)
                                             : coord_t'($urandom_range(0, 160));
    c.frac     = ($urandom_range(0, 4) == 0) ? frac_t'($urandom) : frac_t'($urandom_range(128, 256));
    c.fw       = ($urandom_range(0, 5) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(64, 1920));
    c.fh       = ($urandom_range(0, 5) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(64, 1920));
    return c;
  endfunction

  // Receiver: check each crop transaction, then pick next ready
  initial begin : crop_sink
    rx_mode_e rx_mode;
    int       mode_left, period, beat, hold_left, hold_seen;
    rx_mode = RxSteady;
    mode_left = 0;
    period = 2;
    beat = 0;
    hold_left = 0;
    hold_seen = 0;
    crop_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && crop_if.valid && crop_if.ready)
        book.check_crop({crop_if.crop_valid, crop_if.crop_left, crop_if.crop_top,
                         crop_if.crop_side});
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        crop_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
          period    = $urandom_range(2, 5);
        end
        mode_left--;
        beat++;
        case (rx_mode)
          RxSteady:   crop_if.ready <= 1'b1;
          RxCoin:     crop_if.ready <= ($urandom_range(0, 1) == 1);
          RxSparse:   crop_if.ready <= ($urandom_range(0, 3) == 0);
          RxPeriodic: crop_if.ready <= ((beat % period) == 0);
          default:    crop_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog on stretches with no transaction on either side
  initial begin : idle_watch
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((box_if.valid && box_if.ready) || (crop_if.valid && crop_if.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("%0t no transaction for %0d cycles, %0d crops outstanding",
                 $time, idle, book.pending());
        $display("square_crop_window_calc_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    book = new();
    rst_ni = 1'b0;
    box_if.valid      <= 1'b0;
    box_if.box_valid  <= 1'b0;
    box_if.box_left   <= '0;
    box_if.box_top    <= '0;
    box_if.box_width  <= '0;
    box_if.box_height <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= scw_pkg::RegPadScale;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: frame 320x240, crop limit 180
    directed_boxes.push_back(mk_box(0, 100, 50, 40, 40));      // box flagged invalid
    directed_boxes.push_back(mk_box(1, 100, 50, 0, 30));       // zero width
    directed_boxes.push_back(mk_box(1, 100, 50, 30, 0));       // zero height
    directed_boxes.push_back(mk_box(1, 100, 80, 40, 60));      // plain box
    directed_boxes.push_back(mk_box(1, 0, 0, 1, 1));           // raised to min side
    directed_boxes.push_back(mk_box(1, 150, 100, 117, 10));    // odd side made even
    directed_boxes.push_back(mk_box(1, 100, 60, 119, 119));    // just under the limit
    directed_boxes.push_back(mk_box(1, 100, 60, 120, 50));     // exactly at the limit
    directed_boxes.push_back(mk_box(1, 0, 0, 4095, 4095));     // largest box
    directed_boxes.push_back(mk_box(1, -2048, -2048, 30, 30)); // clamp at origin
    directed_boxes.push_back(mk_box(1, 2047, 2047, 30, 30));   // clamp at far edge
    directed_boxes.push_back(mk_box(1, 3, 9, 5, 7));           // truncating halves
    directed_boxes.push_back(mk_box(0, -1, -1, 4095, 4095));   // invalid, all ones
    foreach (directed_boxes[i]) send_box(directed_boxes[i], 1'b1);
    send_random(90, 1'b1);

    // Widest frame; long receiver hold-off while the sender keeps pushing
    settle();
    apply_setting(mk_cfg(1023, 0, 256, 4095, 4095), 1'b0);
    hold_requests++;
    send_random(90, 1'b0);

    // Scale below one, fraction above one, unused indexes written
    settle();
    apply_setting(mk_cfg(100, 2, 300, 640, 480), 1'b1);
    send_box(mk_box(1, 300, 200, 100, 100), 1'b1);
    send_box(mk_box(1, 0, 0, 4095, 4095), 1'b1);
    send_random(80, 1'b1);

    // Min side at maximum: nothing fits
    settle();
    apply_setting(mk_cfg(256, 4095, 511, 4095, 4095), 1'b0);
    send_random(20, 1'b1);

    // No frame width, then no frame height
    settle();
    apply_setting(mk_cfg(384, 64, 192, 0, 240), 1'b0);
    send_box(mk_box(1, 10, 10, 20, 20), 1'b1);
    send_box(mk_box(1, 0, 0, 1, 1), 1'b1);
    send_random(15, 1'b1);
    settle();
    apply_setting(mk_cfg(384, 64, 192, 320, 0), 1'b0);
    send_random(15, 1'b1);

    // Zero fraction: limit zero
    settle();
    apply_setting(mk_cfg(512, 16, 0, 200, 300), 1'b0);
    send_random(15, 1'b1);

    // Tiny frame with near-zero scale
    settle();
    apply_setting(mk_cfg(1, 0, 256, 1, 2), 1'b0);
    send_random(30, 1'b1);

    // Random settings
    repeat (5) begin
      settle();
      apply_setting(rand_cfg(), $urandom_range(0, 1) == 1);
      send_random(60, $urandom_range(0, 3) != 0);
    end

    settle();
    $display("covered %0d boxes over %0d register settings, incl. a %0d-cycle output stall",
             book.boxes_noted, settings_used, HoldCycles);
    $display("checked %0d crop transactions, %0d with a window", book.crops_checked,
             book.crops_valid);
    if (book.errors == 0) begin
      $display("square_crop_window_calc_tb: done, clean");
    end else begin
      $display("square_crop_window_calc_tb: done, errors");
    end
    $finish;
  end

endmodule
